FILE: hw/rtl/tcfo_pkg.sv
// shared types and codes for the two-class fifo with oldest-first dequeue
// no dependencies; used by every module of the block by scoped name
`default_nettype none

package tcfo_pkg;

	localparam int STAMP_BITS = 16;

	// request modes
	localparam logic [1:0] MODE_ENQ    = 2'd0;
	localparam logic [1:0] MODE_OLDEST = 2'd1;
	localparam logic [1:0] MODE_DEQ0   = 2'd2;
	localparam logic [1:0] MODE_DEQ1   = 2'd3;

	// response status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic        kind;
		logic [31:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        served_kind;
		logic [31:0] out_payload;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcfo_queue.sv
// one class fifo: stamp and payload memory with head, tail and occupancy
// depends on tcfo_pkg for the stamp width
`default_nettype none

module tcfo_queue #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            pop,
	input  wire logic [tcfo_pkg::STAMP_BITS-1:0] wr_stamp,
	input  wire logic [PAYLOAD_BITS-1:0]         wr_data,
	output logic      [tcfo_pkg::STAMP_BITS-1:0] rd_stamp,
	output logic      [PAYLOAD_BITS-1:0]         rd_data,
	output logic                                 empty,
	output logic                                 full
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = tcfo_pkg::STAMP_BITS + PAYLOAD_BITS;

	logic [EW-1:0] mem [QUEUE_DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// memory: one write, one registered read at the head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= {wr_stamp, wr_data};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q  <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
				count_q <= count_q + CW'(1);
			end else if (pop) begin
				head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_stamp = rd_q[EW-1 -: tcfo_pkg::STAMP_BITS];
	assign rd_data  = rd_q[PAYLOAD_BITS-1:0];
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: hw/rtl/tcfo_datapath.sv
// datapath: request register, both class queues, age compare, stamp counter
// and response register; depends on tcfo_pkg and tcfo_queue
`default_nettype none

module tcfo_datapath #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tcfo_pkg::cmd_t       cmd,
	output tcfo_pkg::dp_status_t      status,
	input  wire tcfo_pkg::req_t       req,
	output tcfo_pkg::rsp_t            rsp,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready
);

	localparam int SB = tcfo_pkg::STAMP_BITS;

	tcfo_pkg::req_t    item_q;
	tcfo_pkg::rsp_t    rsp_q;
	logic              rsp_valid_q;
	logic [SB-1:0]     stamp_q;

	logic [1:0]              push;
	logic [1:0]              pop;
	logic [1:0]              empty;
	logic [1:0]              full;
	logic [SB-1:0]           rd_stamp [2];
	logic [PAYLOAD_BITS-1:0] rd_data  [2];
	logic [PAYLOAD_BITS-1:0] wr_data;

	tcfo_pkg::rsp_t    rsp_d;
	logic              do_push;

	assign wr_data = PAYLOAD_BITS'(item_q.payload);

	for (genvar c = 0; c < 2; c++) begin : g_class
		tcfo_queue #(
			.QUEUE_DEPTH (QUEUE_DEPTH),
			.PAYLOAD_BITS(PAYLOAD_BITS)
		) u_queue (
			.clk     (clk),
			.arst_n  (arst_n),
			.push    (push[c]),
			.pop     (pop[c]),
			.wr_stamp(stamp_q),
			.wr_data (wr_data),
			.rd_stamp(rd_stamp[c]),
			.rd_data (rd_data[c]),
			.empty   (empty[c]),
			.full    (full[c])
		);
	end

	// decide the operation for the held request
	always_comb begin
		logic [SB-1:0] diff;
		logic          older0;
		logic          take0;
		logic          take1;
		diff    = rd_stamp[1] - rd_stamp[0];
		older0  = (diff != '0) && !diff[SB-1];
		take0   = 1'b0;
		take1   = 1'b0;
		do_push = 1'b0;
		rsp_d   = '0;
		unique case (item_q.mode)
			tcfo_pkg::MODE_ENQ: begin
				if (full[item_q.kind]) begin
					rsp_d.status = tcfo_pkg::ST_FULL;
				end else begin
					do_push = 1'b1;
				end
			end
			tcfo_pkg::MODE_DEQ0: take0 = !empty[0];
			tcfo_pkg::MODE_DEQ1: take1 = !empty[1];
			tcfo_pkg::MODE_OLDEST: begin
				if (!empty[0] && !empty[1]) begin
					take0 = older0;
					take1 = !older0;
				end else begin
					take0 = !empty[0];
					take1 = !empty[1];
				end
			end
			default: rsp_d.status = tcfo_pkg::ST_EMPTY;
		endcase
		if (item_q.mode != tcfo_pkg::MODE_ENQ) begin
			if (take0) begin
				rsp_d.out_payload = 32'(rd_data[0]);
			end else if (take1) begin
				rsp_d.served_kind = 1'b1;
				rsp_d.out_payload = 32'(rd_data[1]);
			end else begin
				rsp_d.status = tcfo_pkg::ST_EMPTY;
			end
		end
		push = {do_push & item_q.kind, do_push & ~item_q.kind} & {2{cmd.exec}};
		pop  = {take1, take0} & {2{cmd.exec}};
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			stamp_q     <= '0;
		end else begin
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cmd.exec && do_push) begin
				stamp_q <= stamp_q + SB'(1);
			end
		end
	end

	assign status.out_free = !rsp_valid_q || rsp_ready;
	assign rsp             = rsp_q;
	assign rsp_valid       = rsp_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tcfo_ctrl.sv
// controller: takes one request, then executes it once the response slot frees
// depends on tcfo_pkg for the command and status structs
`default_nettype none

module tcfo_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	output tcfo_pkg::cmd_t            cmd,
	input  wire tcfo_pkg::dp_status_t status
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign req_ready  = ready_q;
	assign cmd.accept = req_valid && ready_q;
	assign cmd.exec   = (state_q == S_EXEC) && status.out_free;

endmodule

`default_nettype wire

FILE: hw/rtl/two_class_fifo_oldest_first.sv
// two-class fifo with oldest-first dequeue: top level
// depends on tcfo_pkg, tcfo_ctrl, tcfo_datapath (and through it tcfo_queue)
//
// usage
//   req channel (req_valid/req_ready/req): one transaction per operation;
//     mode selects enqueue, dequeue oldest of either class, or dequeue a
//     given class; kind picks the class of an enqueue
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
//     request: status, served class and dequeued payload (zero unless served)
//   each enqueue stamps its entry with a 16-bit wrapping sequence number;
//     "oldest" compares the two head stamps by modular difference
//   timing: a taken request is held in the request register, executes in
//     S_EXEC once the response slot is free, and lands in the response register
//   pacing: no new request is taken until the last one has executed; the
//     head entries are read from the queue memories through a registered
//     read port, which needs the cycle after each queue update before use
//   reset: both queues empty, stamp zero, req_ready high, no response
//   receiver stall: a finished response waits in the output register; the
//     next request is still taken and its execution waits for the slot
`default_nettype none

module two_class_fifo_oldest_first #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire tcfo_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output tcfo_pkg::rsp_t      rsp
);

	// command and status between controller and datapath
	tcfo_pkg::cmd_t       cmd;
	tcfo_pkg::dp_status_t dp_status;

	// sequencing: accept a transaction, then execute when the response slot frees
	tcfo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd      (cmd),
		.status   (dp_status)
	);

	// queues, stamp counter, age compare and response register
	tcfo_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (dp_status),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/tcfo_checker.sv
// port-level checks for the two-class fifo, bound to the top level
// depends on tcfo_pkg and two_class_fifo_oldest_first
`default_nettype none

module tcfo_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire tcfo_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire tcfo_pkg::rsp_t rsp
);

	// a waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("waiting request changed");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one request at a time: ready drops after a transaction
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in flight");

	// status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == tcfo_pkg::ST_DONE ||
			rsp.status == tcfo_pkg::ST_EMPTY || rsp.status == tcfo_pkg::ST_FULL)
		else $error("undefined status code");

	// nothing served means zero class and zero payload
	a_unserved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != tcfo_pkg::ST_DONE |->
			rsp.served_kind == 1'b0 && rsp.out_payload == '0)
		else $error("unserved response carries data");

endmodule

bind two_class_fifo_oldest_first tcfo_checker u_tcfo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire

FILE: tb/sv/tb_two_class_fifo_oldest_first.sv
// self-checking testbench for two_class_fifo_oldest_first: directed table, then random
// traffic under varied backpressure with a long receiver hold and sender pauses
// depends on tcfo_pkg and two_class_fifo_oldest_first
`timescale 1ns / 100ps

module tb_two_class_fifo_oldest_first;

	localparam int QUEUE_DEPTH = 16;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDLE_LIMIT = 5000;      // cycles with no transaction on either side
	localparam int RX_HOLD_CYCLES = 300;   // long receiver stall so the block backs up
	localparam int SETTLE_CYCLES = 8;      // settle time after the final drain, before the verdict
	localparam int PLAN_ROWS = 16;

	// one entry held by the predictor: its stamp and its payload
	typedef struct packed {
		logic [15:0] stamp;
		logic [31:0] payload;
	} held_entry_t;

	// one row of the directed table; the response is typed in only where it is obvious
	typedef struct {
		tcfo_pkg::req_t op;
		int             reps;
		bit             known;
		tcfo_pkg::rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	tcfo_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	tcfo_pkg::rsp_t rsp;

	// predictor state: the two class queues and the next stamp to hand out
	held_entry_t class0_entries[$];
	held_entry_t class1_entries[$];
	logic [15:0] next_stamp = '0;

	// responses still owed by the block, oldest first
	tcfo_pkg::rsp_t awaited_responses[$];

	int error_count = 0;
	int quiet_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_req = 0;
	int rx_hold_seen = 0;
	int rx_hold_left = 0;

	// directed table: empty reads after reset, extremes of payload, every mode,
	// kind ignored on a dequeue, oldest with one side empty, and a full class
	plan_row_t directed_plan [0:PLAN_ROWS-1] = '{
		'{'{tcfo_pkg::MODE_OLDEST, 1'b0, 32'h0000_0000}, 1, 1'b1,
			'{tcfo_pkg::ST_EMPTY, 1'b0, 32'h0}},
		'{'{tcfo_pkg::MODE_DEQ0,   1'b1, 32'hFFFF_FFFF}, 1, 1'b1,
			'{tcfo_pkg::ST_EMPTY, 1'b0, 32'h0}},
		'{'{tcfo_pkg::MODE_DEQ1,   1'b0, 32'h0000_0000}, 1, 1'b1,
			'{tcfo_pkg::ST_EMPTY, 1'b0, 32'h0}},
		'{'{tcfo_pkg::MODE_ENQ,    1'b0, 32'h0000_0000}, 1, 1'b1,
			'{tcfo_pkg::ST_DONE,  1'b0, 32'h0}},
		'{'{tcfo_pkg::MODE_ENQ,    1'b1, 32'hFFFF_FFFF}, 1, 1'b1,
			'{tcfo_pkg::ST_DONE,  1'b0, 32'h0}},
		'{'{tcfo_pkg::MODE_OLDEST, 1'b1, 32'h0000_0000}, 1, 1'b1,
			'{tcfo_pkg::ST_DONE,  1'b0, 32'h0}},
		'{'{tcfo_pkg::MODE_OLDEST, 1'b0, 32'h0000_0000}, 1, 1'b1,
			'{tcfo_pkg::ST_DONE,  1'b1, 32'hFFFF_FFFF}},
		'{'{tcfo_pkg::MODE_ENQ,    1'b1, 32'hA5A5_A5A5}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_ENQ,    1'b0, 32'h5A5A_5A5A}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_DEQ1,   1'b0, 32'h1234_5678}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_DEQ1,   1'b1, 32'h0000_0000}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_ENQ,    1'b1, 32'h0000_0001}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_OLDEST, 1'b0, 32'h0000_0000}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_OLDEST, 1'b1, 32'h0000_0000}, 1, 1'b0, '0},
		'{'{tcfo_pkg::MODE_ENQ,    1'b0, 32'h1000_0000}, QUEUE_DEPTH, 1'b0, '0},
		'{'{tcfo_pkg::MODE_ENQ,    1'b0, 32'hDEAD_BEEF}, 1, 1'b1,
			'{tcfo_pkg::ST_FULL,  1'b0, 32'h0}}
	};

	two_class_fifo_oldest_first #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// applies one request to the predictor and returns the response it owes
	function automatic tcfo_pkg::rsp_t serve_request(input tcfo_pkg::req_t item);
		tcfo_pkg::rsp_t res;
		int             pick;
		logic [15:0]    age_gap;
		held_entry_t    fresh;
		held_entry_t    popped;
		res = '0;
		pick = -1;
		if (item.mode == tcfo_pkg::MODE_ENQ) begin
			if ((item.kind ? class1_entries.size() : class0_entries.size()) >= QUEUE_DEPTH) begin
				// full class: dropped, stamp stays put
				res.status = tcfo_pkg::ST_FULL;
			end else begin
				fresh = '{next_stamp, item.payload};
				if (item.kind)
					class1_entries = {class1_entries, fresh};
				else
					class0_entries = {class0_entries, fresh};
				next_stamp = next_stamp + 16'd1;
			end
		end else begin
			case (item.mode)
				tcfo_pkg::MODE_DEQ0: begin
					if (class0_entries.size() != 0) pick = 0;
				end
				tcfo_pkg::MODE_DEQ1: begin
					if (class1_entries.size() != 0) pick = 1;
				end
				default: begin
					if (class0_entries.size() != 0 && class1_entries.size() != 0) begin
						// modular age: class 0 is older when its stamp is behind by less than half
						age_gap = class1_entries[0].stamp - class0_entries[0].stamp;
						pick = (age_gap != 16'd0 && age_gap < 16'h8000) ? 0 : 1;
					end else if (class0_entries.size() != 0) begin
						pick = 0;
					end else if (class1_entries.size() != 0) begin
						pick = 1;
					end
				end
			endcase
			if (pick < 0) begin
				res.status = tcfo_pkg::ST_EMPTY;
			end else begin
				popped = (pick == 1) ? class1_entries.pop_front() : class0_entries.pop_front();
				res.served_kind = pick[0];
				res.out_payload = popped.payload;
			end
		end
		return res;
	endfunction

	// offers one transaction, holding it until taken; entered and left at a rising edge
	task automatic offer_request(input tcfo_pkg::req_t item, input bit use_typed,
			input tcfo_pkg::rsp_t typed_rsp);
		tcfo_pkg::rsp_t predicted;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		predicted = serve_request(item);
		if (use_typed)
			predicted = typed_rsp;
		awaited_responses = {awaited_responses, predicted};
	endtask

	// sender pause: nothing offered until every owed response is back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_responses.size() != 0);
	endtask

	// random traffic in runs that lean toward filling, draining, or neither
	task automatic send_mix(input int count);
		tcfo_pkg::req_t item;
		int             enq_pct;
		enq_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 24 == 0) begin
				case ($urandom_range(2))
					0:       enq_pct = 80;
					1:       enq_pct = 20;
					default: enq_pct = 50;
				endcase
			end
			item.kind = 1'($urandom_range(1));
			item.payload = $urandom;
			if ($urandom_range(99) < enq_pct) begin
				item.mode = tcfo_pkg::MODE_ENQ;
			end else begin
				case ($urandom_range(2))
					0:       item.mode = tcfo_pkg::MODE_OLDEST;
					1:       item.mode = tcfo_pkg::MODE_DEQ0;
					default: item.mode = tcfo_pkg::MODE_DEQ1;
				endcase
			end
			offer_request(item, 1'b0, '0);
		end
	endtask

	// receiver: random stalls, or a long hold-off counted down here
	always @(posedge clk) begin
		if (rx_hold_seen != rx_hold_req) begin
			rx_hold_seen = rx_hold_req;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left = rx_hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// response checker: every response transaction against the oldest owed one
	always @(posedge clk) begin : check_rsp
		tcfo_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_responses.size() == 0) begin
				error_count++;
				$display("%0t: response mismatch, expected none, actual %h", $time, rsp);
			end else begin
				want = awaited_responses.pop_front();
				if (rsp.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(rsp.status));
				if (rsp.served_kind !== want.served_kind)
					note_mismatch("served_kind", 32'(want.served_kind),
						32'(rsp.served_kind));
				if (rsp.out_payload !== want.out_payload)
					note_mismatch("out_payload", want.out_payload, rsp.out_payload);
			end
		end
	end

	// watchdog: too long with no transaction on either channel means a hang
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_two_class_fifo_oldest_first failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		tcfo_pkg::req_t item;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (int r = 0; r < PLAN_ROWS; r++) begin
			for (int k = 0; k < directed_plan[r].reps; k++) begin
				item = directed_plan[r].op;
				item.payload = item.payload + 32'(k);
				offer_request(item, directed_plan[r].known, directed_plan[r].want);
			end
		end
		wait_for_drain();

		// sender idles lightly, receiver heavily
		tx_idle_pct = 20;
		rx_idle_pct = 65;
		send_mix(450);
		wait_for_drain();

		// the other way round
		tx_idle_pct = 65;
		rx_idle_pct = 20;
		send_mix(450);
		wait_for_drain();

		// no idling; first a long receiver hold while requests keep coming
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = rx_hold_req + 1;
		send_mix(40);
		send_mix(410);
		wait_for_drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && awaited_responses.size() == 0)
			$display("tb_two_class_fifo_oldest_first passed");
		else
			$display("tb_two_class_fifo_oldest_first failed");
		$finish;
	end

endmodule
